// ===== hdl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Entry layout, request and status codes, cell control bundle.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int PRIO_W   = 8;
	localparam int OCC_W    = 5;

	typedef enum logic {
		REQ_PUSH = 1'b0,
		REQ_POP  = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_POP_EMPTY  = 2'd1,
		STAT_PUSH_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic        [PRIO_W-1:0] prio;
	} entry_t;

	// broadcast to every cell in the chain
	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t item;
	} cell_ctl_t;

endpackage

// ===== hdl/spq_if.sv =====
// ----------------------------------------------------------------------------
// spq_if: request and response channels of the sorted priority queue
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface spq_req_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic signed [31:0] item_value;
	logic        [7:0]  item_priority;

	modport source (output valid, req_type, item_value, item_priority, input ready);
	modport sink   (input valid, req_type, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] popped_value;
	logic               popped_valid;
	logic        [1:0]  status;
	logic signed [31:0] front_value;
	logic        [7:0]  front_priority;
	logic               is_empty;
	logic        [4:0]  occupancy;

	modport source (output valid, popped_value, popped_valid, status, front_value,
		front_priority, is_empty, occupancy, input ready);
	modport sink   (input valid, popped_value, popped_valid, status, front_value,
		front_priority, is_empty, occupancy, output ready);
endinterface

// ===== hdl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue: min-first priority queue in a chain of cells
// Entries sit in a row of cells sorted by ascending priority value.
// ----------------------------------------------------------------------------
// Usage:
//   req  (sink)   : one request per transfer. req_type 0 pushes item_value with
//                   item_priority, req_type 1 pops the front entry.
//   rsp  (source) : exactly one response per request, in request order. It
//                   carries the popped data, a status code (ok, pop on empty,
//                   push on full), the front entry, empty flag and occupancy
//                   as they stand after the request.
// Timing and throughput:
//   On a request every cell compares its priority with the new one in
//   parallel and shifts toward its neighbor in the same edge.
//   The response appears in the output register in the cycle after the request
//   transfer. One request per cycle is sustained while rsp is taken.
// Reset:
//   arst_n clears the entry count and the response valid flag; cell contents
//   are left as they are and are never read until written.
// Stall:
//   While a response waits, req stays ready only if rsp.ready is high in the
//   same cycle; otherwise requests are held off and the response holds.
// ----------------------------------------------------------------------------
module sorted_priority_queue
	import spq_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	spq_req_if.sink  req,
	spq_rsp_if.source rsp
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             accept;
	logic             full;
	logic             empty;
	logic             do_push;
	logic             do_pop;
	cell_ctl_t        ctl;

	entry_t           cell_entry [CAPACITY];
	entry_t           cell_nxt   [CAPACITY];
	logic             cell_ge    [CAPACITY];

	logic               rsp_valid_q;
	logic signed [31:0] popped_value_q;
	logic               popped_valid_q;
	status_t            status_q;
	logic signed [31:0] front_value_q;
	logic        [7:0]  front_priority_q;
	logic               is_empty_q;
	logic        [4:0]  occupancy_q;

	// take a new request whenever the output register is free or drains now
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);

	// drop pushes on a full queue and pops on an empty one
	assign do_push = accept && (req.req_type == REQ_PUSH) && !full;
	assign do_pop  = accept && (req.req_type == REQ_POP) && !empty;

	assign ctl.push       = do_push;
	assign ctl.pop        = do_pop;
	assign ctl.item.data  = req.item_value;
	assign ctl.item.prio  = req.item_priority;

	always_comb begin
		count_nxt = count_q;
		if (do_push) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (do_pop) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	// chain of cells; cell 0 is the front
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic   left_ge;
		entry_t left_entry;
		entry_t right_entry;

		if (i == 0) begin : g_head
			assign left_ge    = 1'b0;
			assign left_entry = '0;
		end else begin : g_body
			assign left_ge    = cell_ge[i-1];
			assign left_entry = cell_entry[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_entry = '0;
		end else begin : g_mid
			assign right_entry = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occupied    (CNT_W'(i) < count_q),
			.at_tail     (CNT_W'(i) == count_q),
			.left_ge     (left_ge),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.ge          (cell_ge[i]),
			.entry       (cell_entry[i]),
			.entry_nxt   (cell_nxt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload: front is the head cell's next value, taken at transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			popped_value_q <= do_pop ? cell_entry[0].data : '0;
			popped_valid_q <= do_pop;
			if (req.req_type == REQ_POP && empty) begin
				status_q <= STAT_POP_EMPTY;
			end else if (req.req_type == REQ_PUSH && full) begin
				status_q <= STAT_PUSH_FULL;
			end else begin
				status_q <= STAT_OK;
			end
			front_value_q    <= (count_nxt != '0) ? cell_nxt[0].data : '0;
			front_priority_q <= (count_nxt != '0) ? cell_nxt[0].prio : '0;
			is_empty_q       <= (count_nxt == '0);
			occupancy_q      <= OCC_W'(count_nxt);
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.popped_value   = popped_value_q;
	assign rsp.popped_valid   = popped_valid_q;
	assign rsp.status         = status_q;
	assign rsp.front_value    = front_value_q;
	assign rsp.front_priority = front_priority_q;
	assign rsp.is_empty       = is_empty_q;
	assign rsp.occupancy      = occupancy_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		do_push |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("accepted push did not grow the queue");

	a_front_order: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CNT_W'(2) |-> cell_entry[0].prio <= cell_entry[1].prio)
		else $error("front entries out of priority order");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.req_type == REQ_POP && empty |=>
			status_q == STAT_POP_EMPTY && !popped_valid_q && count_q == '0)
		else $error("pop on empty queue not flagged");
`endif

endmodule

// ===== hdl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry; on push takes the left entry or the new item or keeps its
// own, on pop takes the right entry.
// ----------------------------------------------------------------------------
module spq_cell
	import spq_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      occupied,
	input  logic      at_tail,
	input  logic      left_ge,
	input  entry_t    left_entry,
	input  entry_t    right_entry,
	output logic      ge,
	output entry_t    entry,
	output entry_t    entry_nxt
);

	entry_t entry_q;

	// stored priority not below the new one: insertion point is here or left
	assign ge    = occupied && (entry_q.prio >= ctl.item.prio);
	assign entry = entry_q;

	always_comb begin
		entry_nxt = entry_q;
		if (ctl.push) begin
			if (left_ge) begin
				entry_nxt = left_entry;
			end else if (ge || at_tail) begin
				entry_nxt = ctl.item;
			end
		end else if (ctl.pop) begin
			entry_nxt = right_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_nxt;
	end

endmodule
